### src/blsp_pkg.sv
package blsp_pkg;

   // Width of the image size registers
   localparam int CFG_BITS = 15;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_BITS-1:0] IMAGE_SIZE_RESET = 15'd900;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   // Per-beat control bits carried from line setup to the walker
   typedef struct packed {
      logic start;
      logic minor_down;
      logic swapped;
   } blsp_ctl_type;

endpackage

### src/blsp_req_if.sv
interface blsp_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

### src/blsp_rsp_if.sv
interface blsp_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic                         pixel_valid;
   logic                         inside_image;
   logic                         last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_valid, inside_image, last_pixel,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_valid, inside_image, last_pixel,
                 output ready);
endinterface

### src/blsp_setup.sv
module blsp_setup
   import blsp_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   blsp_req_if.sink                       req_bus,
   output logic                           out_valid,
   input  logic                           out_ready,
   output blsp_ctl_type                   out_ctl,
   output logic signed [COORD_BITS-1:0]   out_major_pos,
   output logic signed [COORD_BITS-1:0]   out_major_end,
   output logic signed [COORD_BITS-1:0]   out_minor_pos,
   output logic signed [COORD_BITS+1:0]   out_error,
   output logic        [COORD_BITS:0]     out_twice_minor,
   output logic        [COORD_BITS:0]     out_twice_major
);

   localparam int W = COORD_BITS;

   // Input register
   logic                s0_valid_ff;
   logic                s0_start_ff;
   logic signed [W-1:0] s0_x1_ff, s0_y1_ff, s0_x2_ff, s0_y2_ff;

   // Ordered endpoints and extents
   logic                s1_valid_ff;
   logic                s1_start_ff;
   logic                s1_down_ff;
   logic        [W-1:0] s1_dx_ff, s1_dy_ff;
   logic signed [W-1:0] s1_cx_ff, s1_cy_ff, s1_ex_ff, s1_ey_ff;

   // Walk setup
   logic                s2_valid_ff;
   blsp_ctl_type        s2_ctl_ff;
   logic signed [W-1:0] s2_major_pos_ff, s2_major_end_ff, s2_minor_pos_ff;
   logic signed [W+1:0] s2_error_ff;
   logic        [W:0]   s2_tmin_ff, s2_tmaj_ff;

   logic s0_adv, s1_adv, s2_adv;

   assign s2_adv = s2_valid_ff && out_ready;
   assign s1_adv = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign s0_adv = s0_valid_ff && (!s1_valid_ff || s1_adv);
   assign req_bus.ready = !s0_valid_ff || s0_adv;

   // Stage 1 logic: extents and endpoint order
   logic                x_le, y_le;
   logic signed [W:0]   x_fwd, x_rev, y_fwd, y_rev;
   logic        [W-1:0] dx_in, dy_in;
   logic signed [W-1:0] cx_in, cy_in, ex_in, ey_in;
   logic                down_in;

   always_comb begin
      x_le  = s0_x1_ff <= s0_x2_ff;
      y_le  = s0_y1_ff <= s0_y2_ff;
      x_fwd = (W+1)'(s0_x2_ff) - (W+1)'(s0_x1_ff);
      x_rev = (W+1)'(s0_x1_ff) - (W+1)'(s0_x2_ff);
      y_fwd = (W+1)'(s0_y2_ff) - (W+1)'(s0_y1_ff);
      y_rev = (W+1)'(s0_y1_ff) - (W+1)'(s0_y2_ff);
      dx_in = x_le ? x_fwd[W-1:0] : x_rev[W-1:0];
      dy_in = y_le ? y_fwd[W-1:0] : y_rev[W-1:0];
      if (x_le) begin
         cx_in = s0_x1_ff;
         cy_in = s0_y1_ff;
         ex_in = s0_x2_ff;
         ey_in = s0_y2_ff;
      end else begin
         cx_in = s0_x2_ff;
         cy_in = s0_y2_ff;
         ex_in = s0_x1_ff;
         ey_in = s0_y1_ff;
      end
      down_in = ey_in < cy_in;
   end

   // Stage 2 logic: pick the major axis and seed the error term
   blsp_ctl_type        ctl_in;
   logic        [W-1:0] dmaj, dmin;
   logic signed [W-1:0] major_pos_in, major_end_in, minor_pos_in;
   logic signed [W+1:0] error_in;
   logic        [W:0]   tmin_in, tmaj_in;

   always_comb begin
      ctl_in.start      = s1_start_ff;
      ctl_in.minor_down = s1_down_ff;
      ctl_in.swapped    = s1_dx_ff < s1_dy_ff;
      if (ctl_in.swapped) begin
         dmaj = s1_dy_ff;
         dmin = s1_dx_ff;
         if (s1_down_ff) begin
            major_pos_in = s1_ey_ff;
            major_end_in = s1_cy_ff;
            minor_pos_in = s1_ex_ff;
         end else begin
            major_pos_in = s1_cy_ff;
            major_end_in = s1_ey_ff;
            minor_pos_in = s1_cx_ff;
         end
      end else begin
         dmaj         = s1_dx_ff;
         dmin         = s1_dy_ff;
         major_pos_in = s1_cx_ff;
         major_end_in = s1_ex_ff;
         minor_pos_in = s1_cy_ff;
      end
      tmaj_in  = {dmaj, 1'b0};
      tmin_in  = {dmin, 1'b0};
      error_in = signed'((W+2)'(tmin_in) - (W+2)'(dmaj));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            s0_valid_ff <= req_bus.valid;
         end
         if (!s1_valid_ff || s1_adv) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (!s2_valid_ff || s2_adv) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s0_start_ff <= req_bus.action == ACTION_START;
         s0_x1_ff    <= req_bus.start_x;
         s0_y1_ff    <= req_bus.start_y;
         s0_x2_ff    <= req_bus.end_x;
         s0_y2_ff    <= req_bus.end_y;
      end
      if (s0_adv) begin
         s1_start_ff <= s0_start_ff;
         s1_down_ff  <= down_in;
         s1_dx_ff    <= dx_in;
         s1_dy_ff    <= dy_in;
         s1_cx_ff    <= cx_in;
         s1_cy_ff    <= cy_in;
         s1_ex_ff    <= ex_in;
         s1_ey_ff    <= ey_in;
      end
      if (s1_adv) begin
         s2_ctl_ff       <= ctl_in;
         s2_major_pos_ff <= major_pos_in;
         s2_major_end_ff <= major_end_in;
         s2_minor_pos_ff <= minor_pos_in;
         s2_error_ff     <= error_in;
         s2_tmin_ff      <= tmin_in;
         s2_tmaj_ff      <= tmaj_in;
      end
   end

   assign out_valid       = s2_valid_ff;
   assign out_ctl         = s2_ctl_ff;
   assign out_major_pos   = s2_major_pos_ff;
   assign out_major_end   = s2_major_end_ff;
   assign out_minor_pos   = s2_minor_pos_ff;
   assign out_error       = s2_error_ff;
   assign out_twice_minor = s2_tmin_ff;
   assign out_twice_major = s2_tmaj_ff;

endmodule

### src/blsp_walker.sv
module blsp_walker
   import blsp_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic        [CFG_BITS-1:0]     image_width,
   input  logic        [CFG_BITS-1:0]     image_height,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  blsp_ctl_type                   in_ctl,
   input  logic signed [COORD_BITS-1:0]   in_major_pos,
   input  logic signed [COORD_BITS-1:0]   in_major_end,
   input  logic signed [COORD_BITS-1:0]   in_minor_pos,
   input  logic signed [COORD_BITS+1:0]   in_error,
   input  logic        [COORD_BITS:0]     in_twice_minor,
   input  logic        [COORD_BITS:0]     in_twice_major,
   blsp_rsp_if.source                     rsp_bus
);

   localparam int W = COORD_BITS;
   localparam int CMP_BITS = ((W > CFG_BITS) ? W : CFG_BITS) + 1;

   // Line state
   logic                line_active_ff;
   logic signed [W-1:0] major_pos_ff, major_end_ff, minor_pos_ff;
   logic signed [W+1:0] error_ff;
   logic        [W:0]   tmin_ff, tmaj_ff;
   logic                down_ff, swapped_ff;

   // Result register
   logic                rsp_valid_ff;
   logic signed [W-1:0] px_ff, py_ff;
   logic                pv_ff, inside_ff, last_ff;

   logic accept;
   assign in_ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept   = in_valid && in_ready;

   // A start beat walks from the fresh setup, a step beat from the held state
   logic                active;
   logic signed [W-1:0] major_cur, end_cur, minor_cur;
   logic signed [W+1:0] error_cur;
   logic        [W:0]   tmin_cur, tmaj_cur;
   logic                down_cur, swapped_cur;

   logic signed [W-1:0] px, py;
   logic                in_image, last;
   logic signed [W-1:0] major_in, minor_in;
   logic signed [W+1:0] error_in;
   logic                active_in;

   always_comb begin
      if (in_ctl.start) begin
         active      = 1'b1;
         major_cur   = in_major_pos;
         end_cur     = in_major_end;
         minor_cur   = in_minor_pos;
         error_cur   = in_error;
         tmin_cur    = in_twice_minor;
         tmaj_cur    = in_twice_major;
         down_cur    = in_ctl.minor_down;
         swapped_cur = in_ctl.swapped;
      end else begin
         active      = line_active_ff;
         major_cur   = major_pos_ff;
         end_cur     = major_end_ff;
         minor_cur   = minor_pos_ff;
         error_cur   = error_ff;
         tmin_cur    = tmin_ff;
         tmaj_cur    = tmaj_ff;
         down_cur    = down_ff;
         swapped_cur = swapped_ff;
      end

      px       = swapped_cur ? minor_cur : major_cur;
      py       = swapped_cur ? major_cur : minor_cur;
      in_image = !px[W-1] && !py[W-1]
                 && ({{(CMP_BITS-W){1'b0}}, px} < {{(CMP_BITS-CFG_BITS){1'b0}}, image_width})
                 && ({{(CMP_BITS-W){1'b0}}, py} < {{(CMP_BITS-CFG_BITS){1'b0}}, image_height});
      last     = major_cur >= end_cur;

      active_in = active && !last;
      major_in  = major_cur + W'(1);
      if (error_cur[W+1] || error_cur == '0) begin
         error_in = error_cur + signed'((W+2)'(tmin_cur));
         minor_in = minor_cur;
      end else begin
         error_in = error_cur + signed'((W+2)'(tmin_cur)) - signed'((W+2)'(tmaj_cur));
         minor_in = down_cur ? minor_cur - W'(1) : minor_cur + W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            line_active_ff <= active_in;
         end
         if (in_ready) begin
            rsp_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         major_end_ff <= end_cur;
         tmin_ff      <= tmin_cur;
         tmaj_ff      <= tmaj_cur;
         down_ff      <= down_cur;
         swapped_ff   <= swapped_cur;
         // hold position on the last pixel; state is dead after it anyway
         if (active_in) begin
            major_pos_ff <= major_in;
            minor_pos_ff <= minor_in;
            error_ff     <= error_in;
         end else begin
            major_pos_ff <= major_cur;
            minor_pos_ff <= minor_cur;
            error_ff     <= error_cur;
         end
         if (active) begin
            px_ff     <= px;
            py_ff     <= py;
            pv_ff     <= 1'b1;
            inside_ff <= in_image;
            last_ff   <= last;
         end else begin
            px_ff     <= '0;
            py_ff     <= '0;
            pv_ff     <= 1'b0;
            inside_ff <= 1'b0;
            last_ff   <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pixel_x      = px_ff;
   assign rsp_bus.pixel_y      = py_ff;
   assign rsp_bus.pixel_valid  = pv_ff;
   assign rsp_bus.inside_image = inside_ff;
   assign rsp_bus.last_pixel   = last_ff;

endmodule

### src/bresenham_line_stepper.sv
// Path: a request beat passes the setup's input, endpoint and walk-setup registers,
// then the walker's result register. Throughput: one request beat per cycle and one
// pixel per cycle while rsp_bus.ready holds; the walker's single add-and-compare
// step on the error term is the only loop. Reset: synchronous, active high; clears
// the pipeline, drops any active line and sets image width and height to 900.
module bresenham_line_stepper
   import blsp_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   blsp_req_if.sink                  req_bus,
   blsp_rsp_if.source                rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wr_data
);

   logic [CFG_BITS-1:0] image_width_ff;
   logic [CFG_BITS-1:0] image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_SIZE_RESET;
         image_height_ff <= IMAGE_SIZE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wr_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   logic                           setup_valid;
   logic                           setup_ready;
   blsp_ctl_type                   setup_ctl;
   logic signed [COORD_BITS-1:0]   setup_major_pos;
   logic signed [COORD_BITS-1:0]   setup_major_end;
   logic signed [COORD_BITS-1:0]   setup_minor_pos;
   logic signed [COORD_BITS+1:0]   setup_error;
   logic        [COORD_BITS:0]     setup_twice_minor;
   logic        [COORD_BITS:0]     setup_twice_major;

   blsp_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .out_valid       (setup_valid),
      .out_ready       (setup_ready),
      .out_ctl         (setup_ctl),
      .out_major_pos   (setup_major_pos),
      .out_major_end   (setup_major_end),
      .out_minor_pos   (setup_minor_pos),
      .out_error       (setup_error),
      .out_twice_minor (setup_twice_minor),
      .out_twice_major (setup_twice_major)
   );

   blsp_walker #(
      .COORD_BITS (COORD_BITS)
   ) u_walker (
      .clock          (clock),
      .reset          (reset),
      .image_width    (image_width_ff),
      .image_height   (image_height_ff),
      .in_valid       (setup_valid),
      .in_ready       (setup_ready),
      .in_ctl         (setup_ctl),
      .in_major_pos   (setup_major_pos),
      .in_major_end   (setup_major_end),
      .in_minor_pos   (setup_minor_pos),
      .in_error       (setup_error),
      .in_twice_minor (setup_twice_minor),
      .in_twice_major (setup_twice_major),
      .rsp_bus        (rsp_bus)
   );

endmodule
